/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL; included by the top-level file.
// Each macro expects i_clk and i_rst_n in scope and stays quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rlfr_pkg.sv */
`default_nettype none

package rlfr_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_UP_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HS_LOAD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HS_KHZ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_KHZ    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_LIM  = 3'd5;

    // load percent
    localparam int               PCT_W       = 7;
    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] HS_LOAD_RST = 7'd90;

    // delays: 32-bit microseconds times 1000 fits in 42 bits
    localparam int DELAY_US_W = 32;
    localparam int DELAY_NS_W = 42;
    localparam int NS_PER_US  = 1000;

    localparam int TIME_W = 64;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch the input item
        logic prep;       // elapsed time and numerators
        logic cmpt;       // elapsed versus up/down delays
        logic div_start;  // launch the divider
        logic div_raw;    // divider numerator: 1 = frequency, 0 = load
        logic take_load;  // capture load quotient when done
        logic take_raw;   // capture frequency quotient when done
        logic eval;       // pick next target, update state
        logic write;      // load the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic proceed;
        logic div_busy;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hw/rtl/rlfr_div.sv */
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
// A zero divisor gives an all-ones quotient; the caller masks it.
module rlfr_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int               CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(NUM_W - 1);

    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_fit;

    // shift in the next numerator bit and try the subtract
    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff : w_trial;
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* hw/rtl/rlfr_dp.sv */
`default_nettype none

// Datapath: configuration, per-item registers, governor state, divider,
// output register.
module rlfr_dp #(
    parameter int FREQ_BITS = 24,
    parameter int CAP_W     = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [rlfr_pkg::TIME_W-1:0]     i_time_ns,
    input  logic [CAP_W-1:0]               i_utilization,
    input  logic [CAP_W-1:0]               i_capacity,
    input  logic                           i_limits_event,
    input  rlfr_pkg::t_dp_cmd              i_cmd,
    output rlfr_pkg::t_dp_sts              o_sts,
    output logic                           o_changed,
    output logic [FREQ_BITS-1:0]           o_target_khz
);

    localparam int SUM_W   = CAP_W + 1;
    localparam int NUM_W   = FREQ_BITS + SUM_W;
    localparam int LOADN_W = CAP_W + rlfr_pkg::PCT_W;
    localparam int TW      = rlfr_pkg::TIME_W;
    localparam int DNW     = rlfr_pkg::DELAY_NS_W;
    localparam int PW      = rlfr_pkg::PCT_W;

    // configuration
    logic [rlfr_pkg::DELAY_US_W-1:0] r_up_us;
    logic [rlfr_pkg::DELAY_US_W-1:0] r_down_us;
    logic [PW-1:0]                   r_hs_pct;
    logic [FREQ_BITS-1:0]            r_hs_khz;
    logic [FREQ_BITS-1:0]            r_ref_khz;
    logic                            r_force_lim;
    logic [DNW-1:0]                  r_up_ns;
    logic [DNW-1:0]                  r_down_ns;

    // item
    logic [TW-1:0]    r_now;
    logic [CAP_W-1:0] r_util;
    logic [CAP_W-1:0] r_cap;
    logic             r_lim_ev;

    // governor state
    logic [FREQ_BITS-1:0] r_committed;
    logic [TW-1:0]        r_last;
    logic [FREQ_BITS-1:0] r_cached;

    // work registers
    logic [TW-1:0]        r_elapsed;
    logic [NUM_W-1:0]     r_prod;
    logic [LOADN_W-1:0]   r_loadn;
    logic                 r_up_ok;
    logic                 r_down_ok;
    logic [NUM_W-1:0]     r_load;
    logic [FREQ_BITS-1:0] r_raw;
    logic                 r_commit;

    // output
    logic                 r_out_changed;
    logic [FREQ_BITS-1:0] r_out_target;

    logic [PW-1:0]        w_pct_wr;
    logic [SUM_W-1:0]     w_sum;
    logic [NUM_W-1:0]     w_div_num;
    logic                 w_div_busy;
    logic                 w_div_done;
    logic [NUM_W-1:0]     w_div_quo;
    logic                 w_cap_zero;
    logic [FREQ_BITS-1:0] w_raw_sat;
    logic [FREQ_BITS-1:0] w_raw_floor;
    logic                 w_reuse;
    logic [FREQ_BITS-1:0] w_next;
    logic                 w_commit;

    // load threshold write clamps to 100
    assign w_pct_wr = (i_cfg_data[PW-1:0] > rlfr_pkg::PCT_FULL) ?
                      rlfr_pkg::PCT_FULL : i_cfg_data[PW-1:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_us     <= '0;
            r_down_us   <= '0;
            r_hs_pct    <= rlfr_pkg::HS_LOAD_RST;
            r_hs_khz    <= '0;
            r_ref_khz   <= '0;
            r_force_lim <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rlfr_pkg::CFG_UP_DELAY:   r_up_us     <= i_cfg_data;
                rlfr_pkg::CFG_DOWN_DELAY: r_down_us   <= i_cfg_data;
                rlfr_pkg::CFG_HS_LOAD:    r_hs_pct    <= w_pct_wr;
                rlfr_pkg::CFG_HS_KHZ:     r_hs_khz    <= i_cfg_data[FREQ_BITS-1:0];
                rlfr_pkg::CFG_REF_KHZ:    r_ref_khz   <= i_cfg_data[FREQ_BITS-1:0];
                rlfr_pkg::CFG_FORCE_LIM:  r_force_lim <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // delays in ns, refreshed every cycle from the us registers
    always_ff @(posedge i_clk) begin
        r_up_ns   <= DNW'(r_up_us) * DNW'(rlfr_pkg::NS_PER_US);
        r_down_ns <= DNW'(r_down_us) * DNW'(rlfr_pkg::NS_PER_US);
    end

    assign w_sum      = SUM_W'(r_util) + SUM_W'(r_util >> 2);
    assign w_cap_zero = (r_cap == '0);
    assign w_div_num  = i_cmd.div_raw ? r_prod : NUM_W'(r_loadn);

    rlfr_div #(
        .NUM_W (NUM_W),
        .DEN_W (CAP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (r_cap),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // saturate the frequency quotient, then apply the hispeed floor
    always_comb begin
        if (w_cap_zero) begin
            w_raw_sat = '0;
        end else if (|w_div_quo[NUM_W-1:FREQ_BITS]) begin
            w_raw_sat = '1;
        end else begin
            w_raw_sat = w_div_quo[FREQ_BITS-1:0];
        end
        if ((r_hs_khz != '0) && (r_load >= NUM_W'(r_hs_pct)) && (w_raw_sat < r_hs_khz)) begin
            w_raw_floor = r_hs_khz;
        end else begin
            w_raw_floor = w_raw_sat;
        end
    end

    // next target and commit decision
    always_comb begin
        w_reuse = (r_raw == r_cached) && !r_lim_ev;
        w_next  = w_reuse ? r_committed : r_raw;
        if (r_lim_ev) begin
            w_commit = !((r_committed == w_next) && !r_force_lim);
        end else if (r_committed == w_next) begin
            w_commit = 1'b0;
        end else if (w_next > r_committed) begin
            w_commit = r_up_ok;
        end else begin
            w_commit = r_down_ok;
        end
    end

    // governor state; a limits change never survives past its own item,
    // so only these three values carry over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= '0;
            r_last      <= '0;
            r_cached    <= '0;
        end else if (i_cmd.eval) begin
            if (!w_reuse) begin
                r_cached <= r_raw;
            end
            if (w_commit) begin
                r_committed <= w_next;
                r_last      <= r_now;
            end
        end
    end

    // per-item work
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now    <= i_time_ns;
            r_util   <= i_utilization;
            r_cap    <= i_capacity;
            r_lim_ev <= i_limits_event;
        end
        if (i_cmd.prep) begin
            r_elapsed <= r_now - r_last;
            r_prod    <= NUM_W'(r_ref_khz) * NUM_W'(w_sum);
            r_loadn   <= LOADN_W'(r_util) * LOADN_W'(rlfr_pkg::PCT_FULL);
            r_commit  <= 1'b0;
        end
        // a negative elapsed time is shorter than any delay
        if (i_cmd.cmpt) begin
            r_up_ok   <= !r_elapsed[TW-1] && (r_elapsed >= TW'(r_up_ns));
            r_down_ok <= !r_elapsed[TW-1] && (r_elapsed >= TW'(r_down_ns));
        end
        if (i_cmd.take_load && w_div_done) begin
            r_load <= w_cap_zero ? '0 : w_div_quo;
        end
        if (i_cmd.take_raw && w_div_done) begin
            r_raw <= w_raw_floor;
        end
        if (i_cmd.eval) begin
            r_commit <= w_commit;
        end
        if (i_cmd.write) begin
            r_out_changed <= r_commit;
            r_out_target  <= r_committed;
        end
    end

    always_comb begin
        o_sts.proceed  = r_lim_ev || r_up_ok || r_down_ok;
        o_sts.div_busy = w_div_busy;
        o_sts.div_done = w_div_done;
    end

    assign o_changed    = r_out_changed;
    assign o_target_khz = r_out_target;

endmodule

`default_nettype wire

/* hw/rtl/rlfr_ctrl.sv */
`default_nettype none

// Controller: sequences one item through the datapath and owns the
// handshakes of both channels.
module rlfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output rlfr_pkg::t_dp_cmd o_cmd,
    input  rlfr_pkg::t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_CMPT,
        S_CHOOSE,
        S_LOAD_GO,
        S_LOAD_WAIT,
        S_RAW_GO,
        S_RAW_WAIT,
        S_EVAL,
        S_WRITE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_ready;

    // command decode
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:      o_cmd.capture = i_valid;
            S_PREP:      o_cmd.prep = 1'b1;
            S_CMPT:      o_cmd.cmpt = 1'b1;
            S_CHOOSE:    ;
            S_LOAD_GO:   o_cmd.div_start = 1'b1;
            S_LOAD_WAIT: o_cmd.take_load = 1'b1;
            S_RAW_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_raw   = 1'b1;
            end
            S_RAW_WAIT: begin
                o_cmd.take_raw = 1'b1;
                o_cmd.div_raw  = 1'b1;
            end
            S_EVAL:      o_cmd.eval = 1'b1;
            S_WRITE:     o_cmd.write = w_slot_free;
            default:     ;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.write) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP:   r_state <= S_CMPT;
                S_CMPT:   r_state <= S_CHOOSE;
                S_CHOOSE: r_state <= i_sts.proceed ? S_LOAD_GO : S_WRITE;
                S_LOAD_GO: r_state <= S_LOAD_WAIT;
                S_LOAD_WAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_RAW_GO;
                    end
                end
                S_RAW_GO: r_state <= S_RAW_WAIT;
                S_RAW_WAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: r_state <= S_WRITE;
                S_WRITE: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

/* hw/rtl/rate_limited_freq_request.sv */
// Channel   Valid    Ready    Payload
// -------   -------  -------  ---------------------------------------------------
// input     i_valid  o_ready  i_time_ns, i_utilization, i_capacity, i_limits_event
// output    o_valid  i_ready  o_changed, o_target_khz
// config    i_cfg_we (none)   i_cfg_idx, i_cfg_data
//
// An item inside the rate window skips the divider and goes straight to the write step.
// An evaluated item runs the shared one-bit-per-cycle divider twice: once for
// the load percent and once for the frequency.
// Reset is synchronous, active low; config returns to its reset values at once.
// The output register lets the next item start while a result waits; a stalled
// result holds the controller in its write step.
`default_nettype none

`include "assert_macros.svh"

module rate_limited_freq_request #(
    parameter int FREQ_BITS = 24,
    parameter int CAP_SCALE = 1024,
    localparam int CAP_W    = $clog2(CAP_SCALE + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rlfr_pkg::TIME_W-1:0]     i_time_ns,
    input  logic [CAP_W-1:0]               i_utilization,
    input  logic [CAP_W-1:0]               i_capacity,
    input  logic                           i_limits_event,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_changed,
    output logic [FREQ_BITS-1:0]           o_target_khz
);

    rlfr_pkg::t_dp_cmd w_cmd;
    rlfr_pkg::t_dp_sts w_sts;

    rlfr_dp #(
        .FREQ_BITS (FREQ_BITS),
        .CAP_W     (CAP_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_time_ns      (i_time_ns),
        .i_utilization  (i_utilization),
        .i_capacity     (i_capacity),
        .i_limits_event (i_limits_event),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_changed      (o_changed),
        .o_target_khz   (o_target_khz)
    );

    rlfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // one item in flight: no second accept right after the first
    `ASSERT_NXT(a_one_in_flight, i_valid && o_ready, !o_ready, "accept while item in flight")
    // divider is launched only when it is free
    `ASSERT_IMP(a_div_free, w_cmd.div_start, !w_sts.div_busy, "divider started while busy")
    // a quotient only completes while the controller waits for it
    `ASSERT_IMP(a_div_taken, w_sts.div_done, w_cmd.take_load || w_cmd.take_raw, "quotient lost")

endmodule

`default_nettype wire
